FILE: src/vmfp_pkg.sv
// Shared types, codes and sizes for the vote message field parser.
// No dependencies; used by vmfp_step and vote_message_field_parser_core.
`default_nettype none

package vmfp_pkg;

	// Width of the saturating message byte counter
	localparam int COUNT_BITS = 16;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Parse phases
	localparam logic [2:0] PH_LEN   = 3'd0;
	localparam logic [2:0] PH_TAG   = 3'd1;
	localparam logic [2:0] PH_TYPE  = 3'd2;
	localparam logic [2:0] PH_FIXED = 3'd3;
	localparam logic [2:0] PH_STOP  = 3'd4;

	// Result status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_END    = 3'd1;
	localparam logic [2:0] ST_SIZE   = 3'd2;
	localparam logic [2:0] ST_FIELD  = 3'd3;
	localparam logic [2:0] ST_WIRE   = 3'd4;
	localparam logic [2:0] ST_ROUND  = 3'd5;
	localparam logic [2:0] ST_TYPE   = 3'd6;
	localparam logic [2:0] ST_HEIGHT = 3'd7;

	// Configuration register indexes
	localparam logic [1:0] REG_PREVOTE   = 2'd0;
	localparam logic [1:0] REG_PRECOMMIT = 2'd1;
	localparam logic [1:0] REG_PROPOSAL  = 2'd2;
	localparam logic [1:0] REG_SKIP_LIM  = 2'd3;

	// Reset values of the configuration registers
	localparam logic [7:0]  PREVOTE_RST   = 8'd1;
	localparam logic [7:0]  PRECOMMIT_RST = 8'd2;
	localparam logic [7:0]  PROPOSAL_RST  = 8'd32;
	localparam logic [15:0] SKIP_LIM_RST  = 16'd10000;

	// Per-message parse state
	typedef struct packed {
		logic [2:0]            parse_phase;
		logic [COUNT_BITS-1:0] byte_count;
		logic [31:0]           length_accum;
		logic [5:0]            varint_shift;
		logic [2:0]            fixed_index;
		logic                  fixed_target;
		logic [63:0]           fixed_shift;
		logic [7:0]            type_value;
		logic [63:0]           height_value;
		logic [7:0]            round_value;
		logic [2:0]            first_error;
		logic                  skip_seen;
	} parse_state_t;

	// Configuration values seen by the step logic
	typedef struct packed {
		logic [7:0]  prevote_code;
		logic [7:0]  precommit_code;
		logic [7:0]  proposal_code;
		logic [15:0] skip_size_limit;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  vote_type;
		logic [62:0] height;
		logic [7:0]  round;
	} result_t;

endpackage

`default_nettype wire

FILE: src/vmfp_step.sv
// Combinational update of the parse state for one message byte, plus the
// final status check on the last byte. Depends on vmfp_pkg.
`default_nettype none

module vmfp_step (
	input  wire vmfp_pkg::parse_state_t cur,
	input  wire vmfp_pkg::cfg_t         cfg,
	input  wire logic [7:0]             data_byte,
	input  wire logic                   last_byte,
	output vmfp_pkg::parse_state_t      nxt,
	output vmfp_pkg::result_t           res
);

	vmfp_pkg::parse_state_t upd;
	logic        len_bad;
	logic [6:0]  part;
	logic [38:0] len_sum;
	logic [4:0]  fnum;
	logic [2:0]  wtype;
	logic [63:0] fixed_new;
	logic [2:0]  stat;
	logic [32:0] len_plus1;

	assign part      = data_byte[6:0];
	assign fnum      = data_byte[7:3];
	assign wtype     = data_byte[2:0];
	assign len_sum   = {7'd0, cur.length_accum} +
		({32'd0, part} << cur.varint_shift[4:0]);
	assign fixed_new = cur.fixed_shift |
		({56'd0, data_byte} << {cur.fixed_index, 3'b000});

	// Advance the parse state by one byte
	always_comb begin
		upd = cur;
		len_bad = 1'b0;
		if (cur.byte_count != vmfp_pkg::COUNT_MAX) begin
			upd.byte_count = cur.byte_count + 1'b1;
		end
		case (cur.parse_phase)
			vmfp_pkg::PH_LEN: begin
				if (part != 7'd0) begin
					if (cur.varint_shift[5]) begin
						upd.length_accum = 32'hFFFF_FFFF;
					end else if (len_sum[38:32] != 7'd0) begin
						upd.length_accum = 32'hFFFF_FFFF;
					end else begin
						upd.length_accum = len_sum[31:0];
					end
				end
				if (data_byte[7]) begin
					upd.varint_shift = (cur.varint_shift > 6'd56) ? 6'd63 :
						cur.varint_shift + 6'd7;
				end else begin
					upd.parse_phase = vmfp_pkg::PH_TAG;
				end
				len_bad = last_byte;
			end
			vmfp_pkg::PH_TAG: begin
				if (fnum == 5'd0) begin
					upd.first_error = vmfp_pkg::ST_FIELD;
					upd.parse_phase = vmfp_pkg::PH_STOP;
				end else if (fnum == 5'd1) begin
					if (wtype != 3'd0) begin
						upd.first_error = vmfp_pkg::ST_WIRE;
						upd.parse_phase = vmfp_pkg::PH_STOP;
					end else if (last_byte) begin
						upd.first_error = vmfp_pkg::ST_END;
						upd.parse_phase = vmfp_pkg::PH_STOP;
					end else begin
						upd.parse_phase = vmfp_pkg::PH_TYPE;
					end
				end else if (fnum == 5'd2 || fnum == 5'd3) begin
					if (wtype != 3'd1) begin
						upd.first_error = vmfp_pkg::ST_WIRE;
						upd.parse_phase = vmfp_pkg::PH_STOP;
					end else if (last_byte) begin
						upd.first_error = vmfp_pkg::ST_END;
						upd.parse_phase = vmfp_pkg::PH_STOP;
					end else begin
						upd.parse_phase  = vmfp_pkg::PH_FIXED;
						upd.fixed_index  = 3'd0;
						upd.fixed_target = (fnum == 5'd3);
						upd.fixed_shift  = 64'd0;
					end
				end else begin
					upd.skip_seen   = 1'b1;
					upd.parse_phase = vmfp_pkg::PH_STOP;
				end
			end
			vmfp_pkg::PH_TYPE: begin
				upd.type_value  = data_byte;
				upd.parse_phase = vmfp_pkg::PH_TAG;
			end
			vmfp_pkg::PH_FIXED: begin
				upd.fixed_shift = fixed_new;
				if (cur.fixed_index == 3'd7) begin
					upd.parse_phase = vmfp_pkg::PH_TAG;
					if (!cur.fixed_target) begin
						upd.height_value = fixed_new;
					end else if (fixed_new[63:8] != 56'd0) begin
						upd.first_error = vmfp_pkg::ST_ROUND;
						upd.parse_phase = vmfp_pkg::PH_STOP;
					end else begin
						upd.round_value = fixed_new[7:0];
					end
				end else begin
					upd.fixed_index = cur.fixed_index + 3'd1;
					if (last_byte) begin
						upd.first_error = vmfp_pkg::ST_END;
						upd.parse_phase = vmfp_pkg::PH_STOP;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign len_plus1 = {1'b0, upd.length_accum} + 33'd1;

	// Pick the status in priority order
	always_comb begin
		if (upd.byte_count < vmfp_pkg::COUNT_BITS'(2) || len_bad) begin
			stat = vmfp_pkg::ST_END;
		end else if (len_plus1 != 33'(upd.byte_count)) begin
			stat = vmfp_pkg::ST_SIZE;
		end else if (upd.first_error != vmfp_pkg::ST_OK) begin
			stat = upd.first_error;
		end else if (upd.skip_seen &&
			(32'(upd.byte_count) > 32'(cfg.skip_size_limit))) begin
			stat = vmfp_pkg::ST_SIZE;
		end else if (upd.type_value != cfg.prevote_code &&
			upd.type_value != cfg.precommit_code &&
			upd.type_value != cfg.proposal_code) begin
			stat = vmfp_pkg::ST_TYPE;
		end else if (upd.height_value[63]) begin
			stat = vmfp_pkg::ST_HEIGHT;
		end else begin
			stat = vmfp_pkg::ST_OK;
		end
	end

	// Build the result; clear the message state on the last byte
	always_comb begin
		res.status    = stat;
		res.vote_type = 8'd0;
		res.height    = 63'd0;
		res.round     = 8'd0;
		if (stat == vmfp_pkg::ST_OK) begin
			res.vote_type = upd.type_value;
			res.height    = upd.height_value[62:0];
			res.round     = upd.round_value;
		end
		nxt = upd;
		if (last_byte) begin
			nxt = '0;
			nxt.parse_phase = vmfp_pkg::PH_LEN;
		end
	end

endmodule

`default_nettype wire

FILE: src/vote_message_field_parser_core.sv
// Vote message field parser: top level with input, state and result registers.
// Depends on vmfp_pkg and vmfp_step.
//
// Usage:
// - Input channel (in_valid / in_stall, data_byte, last_byte) carries one
//   message byte per transfer; last_byte marks the final byte of a message.
// - Output channel (out_valid / out_stall, status, vote_type, height, round)
//   carries one result per message, produced by the transfer of its last byte.
// - The last byte of a message lands in the input register, and its result is
//   then loaded into the result register from there.
// - Throughput: one byte per cycle while the result register is not stalled;
//   the parse state register updates from the input register on each byte.
// - While the result register is full and stalled, the input register holds
//   and in_stall rises once it is occupied; no byte or result is dropped.
// - Reset clears the parse state, empties both registers and loads the
//   configuration registers with their defaults. Write configuration through
//   cfg_write / cfg_index / cfg_data only while no message is in flight.
`default_nettype none

module vote_message_field_parser_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [7:0]       vote_type,
	output logic [62:0]      height,
	output logic [7:0]       round
);

	vmfp_pkg::cfg_t         cfg_q;
	vmfp_pkg::parse_state_t state_q;
	vmfp_pkg::parse_state_t state_nxt;
	vmfp_pkg::result_t      res;
	vmfp_pkg::result_t      res_q;
	logic                   valid_s1;
	logic [7:0]             data_byte_s1;
	logic                   last_byte_s1;
	logic                   out_valid_q;
	logic                   advance;

	// Stage 1 moves on whenever the result register can take a transfer
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prevote_code    <= vmfp_pkg::PREVOTE_RST;
			cfg_q.precommit_code  <= vmfp_pkg::PRECOMMIT_RST;
			cfg_q.proposal_code   <= vmfp_pkg::PROPOSAL_RST;
			cfg_q.skip_size_limit <= vmfp_pkg::SKIP_LIM_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				vmfp_pkg::REG_PREVOTE:   cfg_q.prevote_code   <= cfg_data[7:0];
				vmfp_pkg::REG_PRECOMMIT: cfg_q.precommit_code <= cfg_data[7:0];
				vmfp_pkg::REG_PROPOSAL:  cfg_q.proposal_code  <= cfg_data[7:0];
				vmfp_pkg::REG_SKIP_LIM:  cfg_q.skip_size_limit <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_byte_s1 <= data_byte;
			last_byte_s1 <= last_byte;
		end
	end

	vmfp_step u_step (
		.cur       (state_q),
		.cfg       (cfg_q),
		.data_byte (data_byte_s1),
		.last_byte (last_byte_s1),
		.nxt       (state_nxt),
		.res       (res)
	);

	// Parse state: advance on each byte leaving stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{parse_phase: vmfp_pkg::PH_LEN, default: '0};
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && last_byte_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && last_byte_s1) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = res_q.status;
	assign vote_type = res_q.vote_type;
	assign height    = res_q.height;
	assign round     = res_q.round;

endmodule

`default_nettype wire

FILE: tb/sv/vote_message_field_parser_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for vote_message_field_parser_core: streams framed vote
// messages byte by byte and checks every status and field result against a
// byte-level parser kept in the bench. Depends on vmfp_pkg and the parser RTL.

module vote_message_field_parser_core_test;
	import vmfp_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 12;
	localparam int DRAIN_CYCLES  = 4;
	localparam int QUIET_LIMIT   = 1000;
	localparam int REPORT_LIMIT  = 10;

	// Tags and wire types of the message format
	localparam logic [7:0] TAG_TYPE   = 8'h08;
	localparam logic [7:0] TAG_HEIGHT = 8'h11;
	localparam logic [7:0] TAG_ROUND  = 8'h19;
	localparam logic [7:0] TAG_SKIP   = 8'h20;
	localparam logic [2:0] WIRE_VARINT  = 3'd0;
	localparam logic [2:0] WIRE_FIXED64 = 3'd1;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_xfer_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [7:0]  vote_type;
	logic [62:0] height;
	logic [7:0]  round;

	vote_message_field_parser_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.vote_type(vote_type),
		.height(height),
		.round(round)
	);

	// Stimulus and expectation stores
	byte_xfer_t  pending_bytes[$];
	result_t     expected_results[$];
	logic [7:0]  body[$];
	logic [7:0]  frame[$];

	// Bench copy of the configuration registers
	logic [7:0]  code_prevote;
	logic [7:0]  code_precommit;
	logic [7:0]  code_proposal;
	logic [15:0] skip_limit;

	// Bench copy of the per-message parse state
	logic [2:0]            p_phase;
	logic [COUNT_BITS-1:0] p_count;
	logic [31:0]           p_len;
	logic [5:0]            p_shift;
	logic [2:0]            p_fidx;
	logic                  p_round_field;
	logic [63:0]           p_fixed;
	logic [7:0]            p_type;
	logic [63:0]           p_height;
	logic [7:0]            p_round;
	logic [2:0]            p_error;
	logic                  p_skipped;

	bit          idle_on;
	bit          in_took;
	int unsigned in_gap;
	int unsigned stall_left;
	int unsigned quiet_cycles;
	int unsigned failures;
	int unsigned results_checked;
	int unsigned msgs_queued;
	int unsigned bytes_queued;
	int unsigned bytes_taken;
	int unsigned status_tally[8];
	byte_xfer_t  next_xfer;

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	task automatic clear_message_state();
		p_phase = PH_LEN;
		p_count = '0;
		p_len = '0;
		p_shift = '0;
		p_fidx = '0;
		p_round_field = 1'b0;
		p_fixed = '0;
		p_type = '0;
		p_height = '0;
		p_round = '0;
		p_error = '0;
		p_skipped = 1'b0;
	endtask

	task automatic stop_with(input logic [2:0] code);
		p_error = code;
		p_phase = PH_STOP;
	endtask

	// Advance the parse state by one byte; on the last byte queue the result
	task automatic parse_vote_byte(input logic [7:0] b, input logic last);
		logic [63:0] sum;
		logic        len_bad;
		logic [4:0]  fnum;
		logic [2:0]  wtype;
		result_t     res;
		len_bad = 1'b0;
		fnum = b[7:3];
		wtype = b[2:0];
		if (p_count != COUNT_MAX)
			p_count = p_count + 1'b1;
		case (p_phase)
			PH_LEN: begin
				if (b[6:0] != 7'd0) begin
					if (p_shift >= 6'd32) begin
						p_len = '1;
					end else begin
						sum = {32'd0, p_len} + ({57'd0, b[6:0]} << p_shift);
						p_len = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
					end
				end
				if (b[7])
					p_shift = (p_shift > 6'd56) ? 6'd63 : p_shift + 6'd7;
				else
					p_phase = PH_TAG;
				if (last)
					len_bad = 1'b1;
			end
			PH_TAG: begin
				if (fnum == 5'd0) begin
					stop_with(ST_FIELD);
				end else if (fnum == 5'd1) begin
					if (wtype != WIRE_VARINT) stop_with(ST_WIRE);
					else if (last) stop_with(ST_END);
					else p_phase = PH_TYPE;
				end else if (fnum == 5'd2 || fnum == 5'd3) begin
					if (wtype != WIRE_FIXED64) begin
						stop_with(ST_WIRE);
					end else if (last) begin
						stop_with(ST_END);
					end else begin
						p_phase = PH_FIXED;
						p_fidx = '0;
						p_round_field = (fnum == 5'd3);
						p_fixed = '0;
					end
				end else begin
					// unknown field: drop the rest of the message
					p_skipped = 1'b1;
					p_phase = PH_STOP;
				end
			end
			PH_TYPE: begin
				p_type = b;
				p_phase = PH_TAG;
			end
			PH_FIXED: begin
				p_fixed = p_fixed | ({56'd0, b} << (8 * p_fidx));
				if (p_fidx == 3'd7) begin
					p_phase = PH_TAG;
					if (!p_round_field)
						p_height = p_fixed;
					else if (p_fixed > 64'd255)
						stop_with(ST_ROUND);
					else
						p_round = p_fixed[7:0];
				end else begin
					p_fidx = p_fidx + 3'd1;
					if (last)
						stop_with(ST_END);
				end
			end
			default: ;
		endcase
		if (last) begin
			if (p_count < 2 || len_bad)
				res.status = ST_END;
			else if (({1'b0, p_len} + 33'd1) != p_count)
				res.status = ST_SIZE;
			else if (p_error != 3'd0)
				res.status = p_error;
			else if (p_skipped && p_count > skip_limit)
				res.status = ST_SIZE;
			else if (p_type != code_prevote && p_type != code_precommit &&
					p_type != code_proposal)
				res.status = ST_TYPE;
			else if (p_height[63])
				res.status = ST_HEIGHT;
			else
				res.status = ST_OK;
			if (res.status == ST_OK) begin
				res.vote_type = p_type;
				res.height = p_height[62:0];
				res.round = p_round;
			end else begin
				res.vote_type = '0;
				res.height = '0;
				res.round = '0;
			end
			expected_results.push_back(res);
			status_tally[res.status]++;
			clear_message_state();
		end
	endtask

	// Hand the assembled frame to the driver, marking its final byte
	task automatic commit_frame();
		int i;
		for (i = 0; i < frame.size(); i++)
			pending_bytes.push_back('{data: frame[i], last: (i == frame.size() - 1)});
		msgs_queued++;
		bytes_queued += frame.size();
		frame.delete();
	endtask

	function automatic int unsigned varint_bytes(input logic [63:0] v);
		int unsigned n;
		n = 1;
		while (v > 64'd127) begin
			v = v >> 7;
			n++;
		end
		return n;
	endfunction

	// Frame = length varint (with optional redundant groups) followed by the body
	task automatic frame_body(input logic [63:0] len_val, input int unsigned pad);
		logic [63:0] v;
		int unsigned i;
		v = len_val;
		do begin
			frame.push_back({(v > 64'd127) || (pad != 0), v[6:0]});
			v = v >> 7;
		end while (v != 0);
		for (i = 1; i <= pad; i++)
			frame.push_back((i == pad) ? 8'h00 : 8'h80);
		for (i = 0; i < body.size(); i++)
			frame.push_back(body[i]);
		body.delete();
		commit_frame();
	endtask

	task automatic push_fixed64(input logic [63:0] v);
		int i;
		for (i = 0; i < 8; i++)
			body.push_back(v[8*i +: 8]);
	endtask

	function automatic logic [7:0] pick_vote_code();
		case ($urandom_range(0, 9))
			0, 1, 2: return code_prevote;
			3, 4:    return code_precommit;
			5, 6:    return code_proposal;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// One random message: mostly well-formed fields, some broken or noise
	task automatic queue_random_message();
		int unsigned n, k, pick, pad, cut;
		logic [63:0] v;
		logic [63:0] len_val;
		logic [4:0]  f;
		int          w;
		if ($urandom_range(0, 99) < 8) begin
			n = $urandom_range(1, 12);
			repeat (n) frame.push_back(8'($urandom_range(0, 255)));
			commit_frame();
			return;
		end
		n = $urandom_range(1, 4);
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				body.push_back(TAG_TYPE);
				body.push_back(pick_vote_code());
			end else if (pick < 55) begin
				body.push_back(TAG_HEIGHT);
				v = {$urandom, $urandom};
				if ($urandom_range(0, 3) != 0)
					v[63] = 1'b0;
				push_fixed64(v);
			end else if (pick < 80) begin
				body.push_back(TAG_ROUND);
				if ($urandom_range(0, 3) != 0)
					v = 64'($urandom_range(0, 255));
				else
					v = {$urandom, $urandom};
				push_fixed64(v);
			end else if (pick < 88) begin
				f = 5'($urandom_range(4, 31));
				w = $urandom_range(0, 7);
				body.push_back({f, w[2:0]});
				k = $urandom_range(0, 5);
				repeat (k) body.push_back(8'($urandom_range(0, 255)));
			end else if (pick < 93) begin
				w = $urandom_range(0, 7);
				body.push_back({5'd0, w[2:0]});
			end else begin
				f = 5'($urandom_range(1, 3));
				if (f == 5'd1) begin
					w = $urandom_range(1, 7);
				end else begin
					w = $urandom_range(2, 8);
					if (w == 8)
						w = 0;
				end
				body.push_back({f, w[2:0]});
			end
		end
		// cut the message short so it ends inside a field
		if ($urandom_range(0, 99) < 12) begin
			cut = $urandom_range(0, body.size());
			while (body.size() > cut)
				body.delete(body.size() - 1);
		end
		pad = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) : 0;
		len_val = 64'(body.size());
		repeat (4) len_val = 64'(varint_bytes(len_val) + pad + body.size() - 1);
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			if ($urandom_range(0, 1) == 0)
				len_val = len_val + 1;
			else
				len_val = len_val - 1;
		end else if (pick < 11) begin
			len_val = {$urandom, $urandom};
		end else if (pick < 13) begin
			pad = $urandom_range(8, 10);
		end
		frame_body(len_val, pad);
	endtask

	task automatic queue_random_bytes(input int unsigned target);
		int unsigned start;
		start = bytes_queued;
		while (bytes_queued - start < target)
			queue_random_message();
	endtask

	task automatic queue_directed();
		frame = '{8'h02, TAG_TYPE, 8'h01};
		commit_frame();
		// single byte, then an unfinished length varint
		frame = '{8'h00};
		commit_frame();
		frame = '{8'h80, 8'h80};
		commit_frame();
		// field zero, wrong wire types
		frame = '{8'h01, 8'h00};
		commit_frame();
		frame = '{8'h01, 8'h09};
		commit_frame();
		frame = '{8'h01, 8'h10};
		commit_frame();
		// message ends on a type or fixed tag
		frame = '{8'h01, TAG_TYPE};
		commit_frame();
		frame = '{8'h01, TAG_HEIGHT};
		commit_frame();
		// skip with no type parsed
		frame = '{8'h01, TAG_SKIP};
		commit_frame();
		// length mismatch
		frame = '{8'h05, TAG_TYPE, 8'h02};
		commit_frame();
		// all fields at their extremes
		body.push_back(TAG_TYPE);
		body.push_back(8'h20);
		body.push_back(TAG_HEIGHT);
		push_fixed64(64'h7FFF_FFFF_FFFF_FFFF);
		body.push_back(TAG_ROUND);
		push_fixed64(64'd255);
		frame_body(64'd20, 0);
		// height with the sign bit set, round just too large
		body.push_back(TAG_TYPE);
		body.push_back(8'h02);
		body.push_back(TAG_HEIGHT);
		push_fixed64(64'h8000_0000_0000_0000);
		frame_body(64'd11, 0);
		body.push_back(TAG_ROUND);
		push_fixed64(64'd256);
		frame_body(64'd9, 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_write = 1'b0;
		case (idx)
			REG_PREVOTE:   code_prevote = val[7:0];
			REG_PRECOMMIT: code_precommit = val[7:0];
			REG_PROPOSAL:  code_proposal = val[7:0];
			REG_SKIP_LIM:  skip_limit = val;
			default: ;
		endcase
	endtask

	task automatic write_codes(input logic [7:0] pv, input logic [7:0] pc,
			input logic [7:0] pp, input logic [15:0] lim);
		write_reg(REG_PREVOTE, {8'd0, pv});
		write_reg(REG_PRECOMMIT, {8'd0, pc});
		write_reg(REG_PROPOSAL, {8'd0, pp});
		write_reg(REG_SKIP_LIM, lim);
	endtask

	// Wait until every byte is in and every result has come out
	task automatic drain();
		do @(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Input driver: hold a stalled transfer, otherwise gap or present the next byte
	always @(negedge clk) begin
		if (!in_valid || in_took) begin
			in_took = 1'b0;
			if (in_gap != 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (idle_on && pending_bytes.size() != 0 && $urandom_range(0, 9) == 0) begin
				in_gap = $urandom_range(0, 8);
				in_valid <= 1'b0;
			end else if (pending_bytes.size() != 0) begin
				next_xfer = pending_bytes.pop_front();
				in_valid <= 1'b1;
				data_byte <= next_xfer.data;
				last_byte <= next_xfer.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: stall in bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 11) == 0) begin
			stall_left = $urandom_range(0, 8);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Predict on every accepted byte
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			parse_vote_byte(data_byte, last_byte);
			in_took = 1'b1;
			bytes_taken++;
		end
	end

	// Check every accepted result against the oldest expectation
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.status = status;
			got.vote_type = vote_type;
			got.height = height;
			got.round = round;
			if (expected_results.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%t: unexpected result status=%0d type=%0d height=%0d round=%0d",
						$realtime, got.status, got.vote_type, got.height, got.round);
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (got.status !== want.status || got.vote_type !== want.vote_type ||
						got.height !== want.height || got.round !== want.round) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display("%t: mismatch status %0d/%0d type %0d/%0d height %0d/%0d round %0d/%0d (exp/act)",
							$realtime, want.status, got.status, want.vote_type, got.vote_type,
							want.height, got.height, want.round, got.round);
				end
			end
		end
	end

	// Watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%t: no transfer for %0d cycles, giving up", $realtime, QUIET_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_PREVOTE;
		cfg_data = '0;
		in_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		out_stall = 1'b0;
		idle_on = 1'b1;
		code_prevote = PREVOTE_RST;
		code_precommit = PRECOMMIT_RST;
		code_proposal = PROPOSAL_RST;
		skip_limit = SKIP_LIM_RST;
		clear_message_state();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults, directed cases
		@(posedge clk);
		queue_directed();
		drain();

		// lowest and highest codes, no skip allowance
		write_codes(8'd0, 8'd255, 8'd128, 16'd0);
		@(posedge clk);
		queue_random_bytes(300);
		drain();

		write_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 16'd20);
		@(posedge clk);
		queue_random_bytes(350);
		drain();

		// widest skip allowance
		write_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 16'hFFFF);
		@(posedge clk);
		queue_random_bytes(100);
		drain();

		// closing stretch at full rate
		write_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 16'($urandom_range(5, 40)));
		idle_on = 1'b0;
		@(posedge clk);
		queue_random_bytes(450);
		drain();

		if (expected_results.size() != 0) begin
			$display("%0d results never arrived", expected_results.size());
			failures += expected_results.size();
		end
		$display("Parsed %0d messages (%0d bytes) under five register settings; %0d results checked.",
			msgs_queued, bytes_taken, results_checked);
		$display("Status mix ok/end/size/field/wire/round/type/height: %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
			status_tally[0], status_tally[1], status_tally[2], status_tally[3],
			status_tally[4], status_tally[5], status_tally[6], status_tally[7]);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
